### rtl/core/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants for the sorted stack engine.
// ----------------------------------------------------------------------------
package sse_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int POS_W       = 7;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_SORT   = 2'd2,
      CMD_SEARCH = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SORT,
      S_SEARCH,
      S_RESP
   } state_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic push;        // shift toward the far end, operand enters cell 0
      logic pop;         // shift toward cell 0
      logic sort;        // one odd-even transposition phase
      logic phase_odd;   // which neighbor pairs compare this phase
      logic load_flags;  // latch key-vs-entry compare flags
   } cell_ctl_type;

endpackage

### rtl/core/sse_chan_if.sv
// ----------------------------------------------------------------------------
// sse_chan_if
// Valid/ready channels for commands and results of the sorted stack engine.
// ----------------------------------------------------------------------------
interface sse_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic signed [31:0] operand_value;

   modport source (output valid, command, operand_value, input ready);
   modport sink   (input valid, command, operand_value, output ready);
endinterface

interface sse_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic signed [31:0] data_out;
   logic [6:0]        found_position;
   logic [6:0]        entry_count;

   modport source (output valid, status, data_out, found_position, entry_count,
                   input ready);
   modport sink   (input valid, status, data_out, found_position, entry_count,
                   output ready);
endinterface

### rtl/core/sorted_stack_engine.sv
// ----------------------------------------------------------------------------
// sorted_stack_engine
// Bounded stack of signed words with in-place ascending sort and binary search.
// ----------------------------------------------------------------------------
//   channel   dir  transfer carries
//   req_chan  in   command, operand_value
//   rsp_chan  out  status, data_out, found_position, entry_count
//
// Push and pop load the result register once the output slot is free after
// the request transfer. Sort runs one odd-even transposition phase per entry
// along the cell chain. Search makes one probe per cycle. One command is in
// work at a time; the next request is taken once the result is in the output
// register, even while it stalls.
// Synchronous reset empties the stack; entries need no clearing.
// ----------------------------------------------------------------------------
module sorted_stack_engine #(
   parameter int STACK_DEPTH = sse_pkg::STACK_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   sse_req_if.sink   req_chan,
   sse_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int IW = $clog2(STACK_DEPTH);
   localparam int PW = sse_pkg::POS_W;

   sse_pkg::cell_ctl_type ctl;
   logic [CW-1:0]         count;
   sse_pkg::word_type     value [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] swap_left;
   logic [STACK_DEPTH-1:0] key_lt;
   logic [STACK_DEPTH-1:0] key_gt;

   logic                  req_fire;
   logic                  rsp_slot_free;
   logic                  rsp_load;
   sse_pkg::status_type   rsp_status;
   sse_pkg::word_type     rsp_data;
   logic [CW-1:0]         rsp_pos;

   logic                  rsp_valid_ff, rsp_valid_in;
   sse_pkg::status_type   status_ff;
   sse_pkg::word_type     data_ff;
   logic [CW-1:0]         pos_ff;
   logic [CW-1:0]         cnt_ff;

   assign req_fire      = req_chan.valid & req_chan.ready;
   assign rsp_slot_free = ~rsp_valid_ff | rsp_chan.ready;

   // sequencer
   sse_ctrl #(
      .DEPTH (STACK_DEPTH),
      .CW    (CW),
      .IW    (IW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .command       (sse_pkg::cmd_type'(req_chan.command)),
      .top_value     (value[0]),
      .key_lt        (key_lt),
      .key_gt        (key_gt),
      .rsp_slot_free (rsp_slot_free),
      .req_ready     (req_chan.ready),
      .ctl           (ctl),
      .count         (count),
      .rsp_load      (rsp_load),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_pos       (rsp_pos)
   );

   // chain of entry cells, cell 0 is the top of stack
   for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
      sse_pkg::word_type left_value;
      sse_pkg::word_type right_value;
      logic              right_swap;

      if (k == 0) begin : g_head
         assign left_value = req_chan.operand_value;
      end else begin : g_mid
         assign left_value = value[k-1];
      end

      if (k == STACK_DEPTH - 1) begin : g_tail
         assign right_value = value[k];
         assign right_swap  = 1'b0;
      end else begin : g_body
         assign right_value = value[k+1];
         assign right_swap  = swap_left[k+1];
      end

      sse_cell #(
         .INDEX (k),
         .CW    (CW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count),
         .key         (req_chan.operand_value),
         .left_value  (left_value),
         .right_value (right_value),
         .right_swap  (right_swap),
         .value       (value[k]),
         .swap_left   (swap_left[k]),
         .key_lt      (key_lt[k]),
         .key_gt      (key_gt[k])
      );
   end

   // result register
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         status_ff <= rsp_status;
         data_ff   <= rsp_data;
         pos_ff    <= rsp_pos;
         cnt_ff    <= count;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.data_out       = data_ff;
   assign rsp_chan.found_position = PW'(pos_ff);
   assign rsp_chan.entry_count    = PW'(cnt_ff);

endmodule

### rtl/core/sse_cell.sv
// ----------------------------------------------------------------------------
// sse_cell
// One stack slot. Cell 0 holds the top entry; deeper entries sit further out.
// ----------------------------------------------------------------------------
module sse_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 7
) (
   input  logic                 clock,
   input  sse_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]        count,
   input  sse_pkg::word_type    key,
   input  sse_pkg::word_type    left_value,   // neighbor nearer the top
   input  sse_pkg::word_type    right_value,  // neighbor nearer the bottom
   input  logic                 right_swap,   // right neighbor wants to swap with us
   output sse_pkg::word_type    value,
   output logic                 swap_left,    // left neighbor is smaller than us
   output logic                 key_lt,
   output logic                 key_gt
);

   localparam logic [CW-1:0] IDX  = CW'(INDEX);
   localparam logic [CW-1:0] IDX1 = CW'(INDEX + 1);
   localparam logic          ODD  = 1'(INDEX % 2);

   sse_pkg::word_type value_ff, value_in;
   logic              lt_ff, gt_ff;

   // pair wants a swap when the entry nearer the top is the smaller one
   assign swap_left = (left_value < value_ff);

   // next entry value
   always_comb begin
      value_in = value_ff;
      if (ctl.push) begin
         value_in = left_value;
      end else if (ctl.pop) begin
         value_in = right_value;
      end else if (ctl.sort) begin
         if (ODD == ctl.phase_odd) begin
            // left member of a pair: partner is one deeper
            if ((IDX1 < count) && right_swap) begin
               value_in = right_value;
            end
         end else begin
            // right member of a pair: partner is one nearer the top
            if ((INDEX != 0) && (IDX < count) && swap_left) begin
               value_in = left_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (ctl.load_flags) begin
         lt_ff <= (key < value_ff);
         gt_ff <= (key > value_ff);
      end
   end

   assign value  = value_ff;
   assign key_lt = lt_ff;
   assign key_gt = gt_ff;

endmodule

### rtl/core/sse_ctrl.sv
// ----------------------------------------------------------------------------
// sse_ctrl
// Command sequencer: fill count, sort phases, binary search walk, result.
// ----------------------------------------------------------------------------
module sse_ctrl #(
   parameter int DEPTH = sse_pkg::STACK_DEPTH,
   parameter int CW    = $clog2(DEPTH + 1),
   parameter int IW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  sse_pkg::cmd_type      command,
   input  sse_pkg::word_type     top_value,
   input  logic [DEPTH-1:0]      key_lt,
   input  logic [DEPTH-1:0]      key_gt,
   input  logic                  rsp_slot_free,
   output logic                  req_ready,
   output sse_pkg::cell_ctl_type ctl,
   output logic [CW-1:0]         count,
   output logic                  rsp_load,
   output sse_pkg::status_type   rsp_status,
   output sse_pkg::word_type     rsp_data,
   output logic [CW-1:0]         rsp_pos
);

   sse_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       phase_ff, phase_in;
   logic [CW-1:0]       low_ff, low_in;
   logic [CW-1:0]       hi_ff, hi_in;       // one past the upper search bound
   logic [CW-1:0]       pos_ff, pos_in;
   sse_pkg::status_type status_ff, status_in;
   sse_pkg::word_type   data_ff, data_in;
   logic                saved_ff, saved_in;  // data_ff holds a popped value

   logic [CW:0]         mid_sum;
   logic [CW-1:0]       mid;
   logic [CW-1:0]       tgt_full;
   logic [IW-1:0]       tgt;
   logic                probe_lt, probe_gt;

   // probe index (low + high) / 2, mapped from bottom position to cell number
   assign mid_sum  = {1'b0, low_ff} + {1'b0, hi_ff} - 1'b1;
   assign mid      = mid_sum[CW:1];
   assign tgt_full = count_ff - CW'(1) - mid;
   assign tgt      = tgt_full[IW-1:0];
   assign probe_lt = key_lt[tgt];
   assign probe_gt = key_gt[tgt];

   // next state and outputs
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      low_in    = low_ff;
      hi_in     = hi_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      data_in   = data_ff;
      saved_in  = saved_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         sse_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               pos_in    = '0;
               saved_in  = 1'b0;
               status_in = sse_pkg::ST_OK;
               state_in  = sse_pkg::S_RESP;
               unique case (command)
                  sse_pkg::CMD_PUSH: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = sse_pkg::ST_FULL;
                     end else begin
                        ctl.push = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  sse_pkg::CMD_POP: begin
                     if (count_ff == '0) begin
                        status_in = sse_pkg::ST_EMPTY;
                     end else begin
                        ctl.pop  = 1'b1;
                        data_in  = top_value;
                        saved_in = 1'b1;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  sse_pkg::CMD_SORT: begin
                     if (count_ff == '0) begin
                        status_in = sse_pkg::ST_EMPTY;
                     end else begin
                        phase_in = '0;
                        state_in = sse_pkg::S_SORT;
                     end
                  end
                  sse_pkg::CMD_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = sse_pkg::ST_EMPTY;
                     end else begin
                        ctl.load_flags = 1'b1;
                        low_in   = '0;
                        hi_in    = count_ff;
                        state_in = sse_pkg::S_SEARCH;
                     end
                  end
                  default: begin
                     state_in = sse_pkg::S_RESP;
                  end
               endcase
            end
         end
         sse_pkg::S_SORT: begin
            // count phases of odd-even transposition leave the entries ordered
            ctl.sort      = 1'b1;
            ctl.phase_odd = phase_ff[0];
            phase_in      = phase_ff + CW'(1);
            if (phase_ff == count_ff - CW'(1)) begin
               state_in = sse_pkg::S_RESP;
            end
         end
         sse_pkg::S_SEARCH: begin
            if (hi_ff > low_ff) begin
               if (probe_lt) begin
                  hi_in = mid;
               end else if (probe_gt) begin
                  low_in = mid + CW'(1);
               end else begin
                  pos_in   = mid + CW'(1);
                  state_in = sse_pkg::S_RESP;
               end
            end else begin
               status_in = sse_pkg::ST_NOT_FOUND;
               state_in  = sse_pkg::S_RESP;
            end
         end
         sse_pkg::S_RESP: begin
            rsp_load = rsp_slot_free;
            if (rsp_slot_free) begin
               state_in = sse_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sse_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sse_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      phase_ff  <= phase_in;
      low_ff    <= low_in;
      hi_ff     <= hi_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      saved_ff  <= saved_in;
   end

   assign count      = count_ff;
   assign rsp_status = status_ff;
   assign rsp_pos    = pos_ff;
   assign rsp_data   = saved_ff ? data_ff : ((count_ff == '0) ? '0 : top_value);

endmodule

### rtl/core/sse_checker.sv
// ----------------------------------------------------------------------------
// sse_checker
// Port-level checks on the sorted stack engine, bound to the top level.
// ----------------------------------------------------------------------------
module sse_checker #(
   parameter int STACK_DEPTH = sse_pkg::STACK_DEPTH
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  status,
   input logic [31:0] data_out,
   input logic [6:0]  found_position,
   input logic [6:0]  entry_count
);

   localparam logic [6:0] FULL_CNT = 7'(STACK_DEPTH);

   logic [1:0] owed_ff, owed_in;

   // requests taken minus results handed out
   always_comb begin
      owed_in = owed_ff;
      if ((req_valid & req_ready) && !(rsp_valid & rsp_ready)) begin
         owed_in = owed_ff + 2'd1;
      end else if (!(req_valid & req_ready) && (rsp_valid & rsp_ready)) begin
         owed_in = owed_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else begin
         owed_ff <= owed_in;
      end
   end

   // a stalled result holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(data_out)
         && $stable(found_position) && $stable(entry_count))
      else $error("result changed while stalled");

   // every result answers an earlier request
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> owed_ff != 2'd0)
      else $error("result without a pending request");

   // empty stack reports nothing held
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == sse_pkg::ST_EMPTY |->
         data_out == '0 && found_position == '0 && entry_count == '0)
      else $error("empty result carries data");

   // a position is only reported on a hit
   a_pos_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && found_position != '0 |-> status == sse_pkg::ST_OK)
      else $error("position reported without a hit");

   // full is reported only at capacity
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == sse_pkg::ST_FULL |-> entry_count == FULL_CNT)
      else $error("full reported below capacity");

endmodule

bind sorted_stack_engine sse_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_sse_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .status         (rsp_chan.status),
   .data_out       (rsp_chan.data_out),
   .found_position (rsp_chan.found_position),
   .entry_count    (rsp_chan.entry_count)
);
